/* sv/bmb_pkg.sv */
package bmb_pkg;

    // Bag sizing.
    localparam int CAPACITY   = 16;
    localparam int ITEM_WIDTH = 32;

    // Width of the value field on the input channel.
    localparam int IN_W      = 32;
    // Stored key width: the value field masked to the item width.
    localparam int KEY_W     = (ITEM_WIDTH < IN_W) ? ITEM_WIDTH : IN_W;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W = 5;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_COUNT  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // Query token that travels down the row of cells, one cell per cycle.
    typedef struct packed {
        t_op  op;
        t_key value;
        t_cnt count;
        logic found;
        t_idx idx;
        t_key last;
    } t_tok;

    // Slot write broadcast to all cells.
    typedef struct packed {
        logic en;
        t_idx idx;
        t_key data;
    } t_wr;

endpackage

/* sv/bmb_if.sv */
// Request channel: opcode and value.
interface bmb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

// Result channel.
interface bmb_out_if;
    logic       valid;
    logic       ready;
    logic       success;
    logic [4:0] match_count;
    logic       present;
    logic [4:0] size_now;
    logic       is_empty;

    modport source (output valid, output success, output match_count, output present,
                    output size_now, output is_empty, input ready);
    modport sink   (input valid, input success, input match_count, input present,
                    input size_now, input is_empty, output ready);
endinterface

/* sv/bmb_cell.sv */
module bmb_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bmb_pkg::t_idx i_index,
    input  bmb_pkg::t_cnt i_fill,
    input  bmb_pkg::t_wr  i_wr,
    input  logic          i_valid,
    input  bmb_pkg::t_tok i_tok,
    output logic          o_valid,
    output bmb_pkg::t_tok o_tok
);

    bmb_pkg::t_key r_data;
    logic          r_valid;
    bmb_pkg::t_tok r_tok;
    bmb_pkg::t_tok n_tok;
    logic          w_active;
    logic          w_hit;
    logic          w_is_last;

    // Compare the passing token against this slot and update its running tallies.
    always_comb begin
        n_tok     = i_tok;
        w_active  = i_valid && (bmb_pkg::t_cnt'(i_index) < i_fill);
        w_hit     = w_active && (r_data == i_tok.value);
        w_is_last = w_active && ((bmb_pkg::t_cnt'(i_index) + bmb_pkg::t_cnt'(1)) == i_fill);
        if (w_hit) begin
            n_tok.count = i_tok.count + bmb_pkg::t_cnt'(1);
        end
        if (w_hit && !i_tok.found) begin
            n_tok.found = 1'b1;
            n_tok.idx   = i_index;
        end
        if (w_is_last) begin
            n_tok.last = r_data;
        end
    end

    // Token stage toward the next cell, and the slot itself.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_tok <= n_tok;
        if (i_wr.en && (i_wr.idx == i_index)) begin
            r_data <= i_wr.data;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;

endmodule

/* sv/bounded_multiset_bag.sv */
// Channel   Dir  Transfer when         Payload
// i_in      in   valid && ready        opcode[1:0], value[31:0]
// o_out     out  valid && ready        success, match_count, present, size_now, is_empty
//
// One request is in flight at a time. Add, remove and count send a token down the
// row of CAPACITY cells, one cell per cycle, before their result is formed; a clear
// skips the row and goes straight to the done state.
// Reset clears the fill count and all control state; the slots are not cleared.
// A result waits in the output register; a request that finishes while it waits
// holds its write-back until the result is taken.
module bounded_multiset_bag (
    input  logic i_clk,
    input  logic i_rst_n,
    bmb_in_if.sink    i_in,
    bmb_out_if.source o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state              r_state;
    logic                r_inj_v;
    bmb_pkg::t_tok       r_inj;
    bmb_pkg::t_tok       r_tok;
    bmb_pkg::t_cnt       r_fill;
    logic                r_ov;
    logic                r_success;
    logic [4:0]          r_match_count;
    logic                r_present;
    logic [4:0]          r_size_now;
    logic                r_is_empty;

    logic [bmb_pkg::CAPACITY:0] v_chain;
    bmb_pkg::t_tok              tok_chain [bmb_pkg::CAPACITY+1];

    bmb_pkg::t_wr  w_wr;
    bmb_pkg::t_cnt n_fill;
    logic          n_success;
    logic          w_commit;
    logic          w_in_xfer;
    bmb_pkg::t_tok w_new_tok;

    assign w_in_xfer = i_in.valid && i_in.ready;
    assign w_commit  = (r_state == S_DONE) && (!r_ov || o_out.ready);

    // Fresh token for an accepted request.
    always_comb begin
        w_new_tok       = '0;
        w_new_tok.op    = bmb_pkg::t_op'(i_in.opcode);
        w_new_tok.value = bmb_pkg::t_key'(i_in.value);
    end

    // Row of cells.
    assign v_chain[0]   = r_inj_v;
    assign tok_chain[0] = r_inj;

    for (genvar g = 0; g < bmb_pkg::CAPACITY; g++) begin : g_cell
        bmb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (bmb_pkg::t_idx'(g)),
            .i_fill  (r_fill),
            .i_wr    (w_wr),
            .i_valid (v_chain[g]),
            .i_tok   (tok_chain[g]),
            .o_valid (v_chain[g+1]),
            .o_tok   (tok_chain[g+1])
        );
    end

    // Write-back and new fill count from the finished token.
    always_comb begin
        w_wr      = '0;
        n_fill    = r_fill;
        n_success = 1'b1;
        unique case (r_tok.op)
            bmb_pkg::OP_ADD: begin
                if (r_fill < bmb_pkg::t_cnt'(bmb_pkg::CAPACITY)) begin
                    w_wr.en   = w_commit;
                    w_wr.idx  = bmb_pkg::t_idx'(r_fill);
                    w_wr.data = r_tok.value;
                    n_fill    = r_fill + bmb_pkg::t_cnt'(1);
                end else begin
                    n_success = 1'b0;
                end
            end
            bmb_pkg::OP_REMOVE: begin
                if (r_tok.found && (r_fill != '0)) begin
                    w_wr.en   = w_commit;
                    w_wr.idx  = r_tok.idx;
                    w_wr.data = r_tok.last;
                    n_fill    = r_fill - bmb_pkg::t_cnt'(1);
                end else begin
                    n_success = 1'b0;
                end
            end
            bmb_pkg::OP_CLEAR: begin
                n_fill = '0;
            end
            default: begin
            end
        endcase
    end

    // Sequencer, fill count and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_inj_v <= 1'b0;
            r_fill  <= '0;
            r_ov    <= 1'b0;
        end else begin
            // A token enters the row only for a request that needs the scan.
            r_inj_v <= w_in_xfer && (bmb_pkg::t_op'(i_in.opcode) != bmb_pkg::OP_CLEAR);
            if (o_out.valid && o_out.ready && !w_commit) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        if (bmb_pkg::t_op'(i_in.opcode) == bmb_pkg::OP_CLEAR) begin
                            r_tok   <= w_new_tok;
                            r_state <= S_DONE;
                        end else begin
                            r_inj   <= w_new_tok;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (v_chain[bmb_pkg::CAPACITY]) begin
                        r_tok   <= tok_chain[bmb_pkg::CAPACITY];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_commit) begin
                        r_fill        <= n_fill;
                        r_ov          <= 1'b1;
                        r_success     <= n_success;
                        r_match_count <= bmb_pkg::OUT_CNT_W'(r_tok.count);
                        r_present     <= (r_tok.count != '0);
                        r_size_now    <= bmb_pkg::OUT_CNT_W'(n_fill);
                        r_is_empty    <= (n_fill == '0);
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_ov;
    assign o_out.success     = r_success;
    assign o_out.match_count = r_match_count;
    assign o_out.present     = r_present;
    assign o_out.size_now    = r_size_now;
    assign o_out.is_empty    = r_is_empty;

    // The row is empty whenever a new request may be taken.
    a_idle_row_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (v_chain == '0))
        else $error("token left in the cell row while idle");

    // At most one token travels down the row.
    a_single_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(v_chain))
        else $error("more than one token in the cell row");

    // The fill count never passes the capacity.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= bmb_pkg::t_cnt'(bmb_pkg::CAPACITY))
        else $error("fill count above capacity");

    // A request transfer always leaves the idle state.
    a_xfer_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state != S_IDLE))
        else $error("request transfer did not start work");

endmodule

/* tb/bounded_multiset_bag_tb.sv */
`timescale 1ns / 100ps

module bounded_multiset_bag_tb;

    // One result of the bag, laid out as the output channel carries it.
    typedef struct packed {
        logic       success;
        logic [4:0] match_count;
        logic       present;
        logic [4:0] size_now;
        logic       is_empty;
    } t_bag_result;

    // One row of the directed stimulus; a typed result is used when has_want is set.
    typedef struct {
        bmb_pkg::t_op op;
        logic [31:0]  value;
        bit           has_want;
        t_bag_result  want;
    } t_stim_row;

    localparam int NUM_RANDOM_ITEMS = 1100;

    logic i_clk;
    logic i_rst_n;

    bmb_in_if  in_if ();
    bmb_out_if out_if ();

    bounded_multiset_bag u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    // Shadow copy of the bag contents.
    bmb_pkg::t_key bag_slots [bmb_pkg::CAPACITY];
    int            bag_fill = 0;
    t_bag_result   pending_results [$];
    int            error_count = 0;
    int unsigned   cycle_count = 0;
    logic          calm;

    // Directed rows: extremes, every operation, full bag, absent value and last-entry remove.
    t_stim_row dir_rows [0:24] = '{
        '{bmb_pkg::OP_COUNT,  32'h0000_0000, 1'b1, '{1'b1, 5'd0, 1'b0, 5'd0, 1'b1}},
        '{bmb_pkg::OP_REMOVE, 32'h0000_0005, 1'b1, '{1'b0, 5'd0, 1'b0, 5'd0, 1'b1}},
        '{bmb_pkg::OP_ADD,    32'h0000_0000, 1'b1, '{1'b1, 5'd0, 1'b0, 5'd1, 1'b0}},
        '{bmb_pkg::OP_ADD,    32'hFFFF_FFFF, 1'b1, '{1'b1, 5'd0, 1'b0, 5'd2, 1'b0}},
        '{bmb_pkg::OP_COUNT,  32'hFFFF_FFFF, 1'b1, '{1'b1, 5'd1, 1'b1, 5'd2, 1'b0}},
        '{bmb_pkg::OP_REMOVE, 32'h0000_0000, 1'b0, '0},
        '{bmb_pkg::OP_ADD,    32'h5A5A_5A5A, 1'b0, '0},
        '{bmb_pkg::OP_ADD,    32'h5A5A_5A5A, 1'b0, '0},
        '{bmb_pkg::OP_ADD,    32'h5A5A_5A5A, 1'b0, '0},
        '{bmb_pkg::OP_ADD,    32'h5A5A_5A5A, 1'b0, '0},
        '{bmb_pkg::OP_ADD,    32'h5A5A_5A5A, 1'b0, '0},
        '{bmb_pkg::OP_ADD,    32'h5A5A_5A5A, 1'b0, '0},
        '{bmb_pkg::OP_ADD,    32'h5A5A_5A5A, 1'b0, '0},
        '{bmb_pkg::OP_ADD,    32'h5A5A_5A5A, 1'b0, '0},
        '{bmb_pkg::OP_ADD,    32'h5A5A_5A5A, 1'b0, '0},
        '{bmb_pkg::OP_ADD,    32'h5A5A_5A5A, 1'b0, '0},
        '{bmb_pkg::OP_ADD,    32'h5A5A_5A5A, 1'b0, '0},
        '{bmb_pkg::OP_ADD,    32'h5A5A_5A5A, 1'b0, '0},
        '{bmb_pkg::OP_ADD,    32'h5A5A_5A5A, 1'b0, '0},
        '{bmb_pkg::OP_ADD,    32'h5A5A_5A5A, 1'b0, '0},
        '{bmb_pkg::OP_ADD,    32'h8000_0000, 1'b0, '0},
        '{bmb_pkg::OP_ADD,    32'h0000_0001, 1'b1, '{1'b0, 5'd0, 1'b0, 5'd16, 1'b0}},
        '{bmb_pkg::OP_REMOVE, 32'h8000_0000, 1'b0, '0},
        '{bmb_pkg::OP_REMOVE, 32'h0001_2345, 1'b0, '0},
        '{bmb_pkg::OP_CLEAR,  32'hAAAA_5555, 1'b1, '{1'b1, 5'd0, 1'b0, 5'd0, 1'b1}}
    };

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("bounded_multiset_bag_tb NOT OK");
        $finish;
    end

    // Cycle counter; a window in the middle of the run has no idling on either side.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end
    assign calm = (cycle_count >= 8000) && (cycle_count < 12000);

    // Result side stalls at random outside the calm window.
    always @(posedge i_clk) begin
        out_if.ready <= calm || ($urandom_range(0, 99) >= 6);
    end

    // Apply one operation to the shadow bag and return the result it should give.
    function automatic t_bag_result apply_bag_op(bmb_pkg::t_op op, logic [31:0] value);
        bmb_pkg::t_key key;
        int            hits;
        int            first_hit;
        int            i;
        t_bag_result   res;
        key       = bmb_pkg::t_key'(value);
        hits      = 0;
        first_hit = -1;
        res       = '0;
        res.success = 1'b1;
        if (op != bmb_pkg::OP_CLEAR) begin
            for (i = 0; i < bag_fill; i++) begin
                if (bag_slots[i] == key) begin
                    if (first_hit < 0) first_hit = i;
                    hits++;
                end
            end
        end
        case (op)
            bmb_pkg::OP_ADD: begin
                if (bag_fill < bmb_pkg::CAPACITY) begin
                    bag_slots[bag_fill] = key;
                    bag_fill++;
                end else begin
                    res.success = 1'b0;
                end
            end
            bmb_pkg::OP_REMOVE: begin
                // The last entry fills the hole left by the first match.
                if (first_hit >= 0) begin
                    bag_fill--;
                    bag_slots[first_hit] = bag_slots[bag_fill];
                end else begin
                    res.success = 1'b0;
                end
            end
            bmb_pkg::OP_CLEAR: begin
                bag_fill = 0;
            end
            default: begin
            end
        endcase
        res.match_count = hits[4:0];
        res.present     = (hits != 0);
        res.size_now    = bag_fill[4:0];
        res.is_empty    = (bag_fill == 0);
        return res;
    endfunction

    // Drive one request and hold it until the transfer, then record its result.
    task automatic send_request(bmb_pkg::t_op op, logic [31:0] value, bit has_want,
                                t_bag_result want);
        t_bag_result predicted;
        in_if.valid  <= 1'b1;
        in_if.opcode <= op;
        in_if.value  <= value;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        predicted = apply_bag_op(op, value);
        pending_results.push_back(has_want ? want : predicted);
    endtask

    // Random gap on the request side; lengths cover every phase of a scan.
    task automatic request_pause();
        if (!calm && ($urandom_range(0, 99) < 6)) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, bmb_pkg::CAPACITY + 6)) @(posedge i_clk);
        end
    endtask

    // Compare every result transfer with the oldest pending result.
    always @(posedge i_clk) begin
        t_bag_result got;
        t_bag_result want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got = '{out_if.success, out_if.match_count, out_if.present,
                    out_if.size_now, out_if.is_empty};
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result ok=%b cnt=%0d pres=%b size=%0d empty=%b",
                         $time, got.success, got.match_count, got.present, got.size_now,
                         got.is_empty);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    error_count++;
                    $display("%0t: mismatch expected ok=%b cnt=%0d pres=%b size=%0d empty=%b",
                             $time, want.success, want.match_count, want.present,
                             want.size_now, want.is_empty);
                    $display("%0t:          actual   ok=%b cnt=%0d pres=%b size=%0d empty=%b",
                             $time, got.success, got.match_count, got.present,
                             got.size_now, got.is_empty);
                end
            end
        end
    end

    // Reset, directed rows, random segments, drain and verdict.
    initial begin
        logic [31:0]  value_pool [8];
        int           pool_size;
        int           seg_len;
        int           sent;
        int           roll;
        int           k;
        bit           fill_mode;
        bmb_pkg::t_op op;
        logic [31:0]  value;

        in_if.valid  <= 1'b0;
        in_if.opcode <= bmb_pkg::OP_ADD;
        in_if.value  <= '0;
        i_rst_n      <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (dir_rows[r]) begin
            request_pause();
            send_request(dir_rows[r].op, dir_rows[r].value, dir_rows[r].has_want,
                         dir_rows[r].want);
        end

        // Random segments: a small pool of values so that duplicates, full bags and
        // successful removes are common, with some fully random values as noise.
        sent      = 0;
        fill_mode = 1'b1;
        while (sent < NUM_RANDOM_ITEMS) begin
            pool_size = $urandom_range(1, 6);
            for (k = 0; k < pool_size; k++) begin
                roll = $urandom_range(0, 9);
                value_pool[k] = (roll == 0) ? 32'h0000_0000 :
                                (roll == 1) ? 32'hFFFF_FFFF : $urandom;
            end
            seg_len = $urandom_range(20, 60);
            for (k = 0; k < seg_len && sent < NUM_RANDOM_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                if (fill_mode) begin
                    op = (roll < 60) ? bmb_pkg::OP_ADD : (roll < 80) ? bmb_pkg::OP_REMOVE :
                         (roll < 97) ? bmb_pkg::OP_COUNT : bmb_pkg::OP_CLEAR;
                end else begin
                    op = (roll < 25) ? bmb_pkg::OP_ADD : (roll < 70) ? bmb_pkg::OP_REMOVE :
                         (roll < 98) ? bmb_pkg::OP_COUNT : bmb_pkg::OP_CLEAR;
                end
                value = ($urandom_range(0, 9) == 0) ? $urandom :
                        value_pool[$urandom_range(0, pool_size - 1)];
                request_pause();
                send_request(op, value, 1'b0, '0);
                sent++;
            end
            fill_mode = ~fill_mode;
        end
        in_if.valid <= 1'b0;

        // Wait for every pending result, then a little longer for stray outputs.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (bmb_pkg::CAPACITY + 8) @(posedge i_clk);

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("bounded_multiset_bag_tb OK");
        end else begin
            $display("bounded_multiset_bag_tb NOT OK");
        end
        $finish;
    end

endmodule
